### src/cbts_pkg.sv
// Shared types, constants and the control store for the CAN bit-timing solver.
// No dependencies; every other file of the block imports this package.
package cbts_pkg;

	// Field widths of the request and result words
	localparam int CLOCK_W = 30;
	localparam int RATE_W  = 20;
	localparam int SP_W    = 10;
	localparam int PRESC_W = 10;
	localparam int SEG1_W  = 4;
	localparam int SEG2_W  = 3;
	localparam int ATT_W   = 2;

	// Default limits of the timing register fields
	localparam int DEF_MAX_PRESCALER = 1024;
	localparam int DEF_MAX_SEG1      = 16;
	localparam int DEF_MAX_SEG2      = 8;

	// Divider step counter
	localparam int CNT_W = $clog2(CLOCK_W);

	// Attempt codes: split offset 0, +1, -1
	localparam logic [ATT_W-1:0] ATT_NONE  = 2'd0;
	localparam logic [ATT_W-1:0] ATT_PLUS  = 2'd1;
	localparam logic [ATT_W-1:0] ATT_MINUS = 2'd2;

	typedef struct packed {
		logic [CLOCK_W-1:0] clock_hz;
		logic [RATE_W-1:0]  bit_rate;
		logic [SP_W-1:0]    sample_point;
	} request_t;

	typedef struct packed {
		logic               ok;
		logic [PRESC_W-1:0] prescaler_field;
		logic [SEG1_W-1:0]  seg1_field;
		logic [SEG2_W-1:0]  seg2_field;
		logic [ATT_W-1:0]   attempt_used;
	} result_t;

	// Datapath operations
	typedef enum logic [3:0] {
		OP_NOP,
		OP_LOAD,
		OP_DIV_STEP,
		OP_BASE,
		OP_SPLIT,
		OP_GCD_PAIR,
		OP_A_HALVE,
		OP_B_HALVE,
		OP_GCD_SUB,
		OP_SET_P,
		OP_SEG_INIT,
		OP_SEG_STEP,
		OP_ATT_INC,
		OP_EMIT_OK,
		OP_EMIT_FAIL
	} op_t;

	// Jump conditions
	typedef enum logic [3:0] {
		C_NEVER,
		C_ALWAYS,
		C_RATE_ZERO,
		C_DIV_MORE,
		C_Q_BIG,
		C_SPLIT_BAD,
		C_BOTH_EVEN,
		C_A_EVEN,
		C_B_EVEN,
		C_A_NE_B,
		C_SEG_BAD,
		C_SEG_MORE,
		C_ATT_LAST
	} cond_t;

	// Status flags from the datapath to the sequencer
	typedef struct packed {
		logic rate_zero;
		logic div_more;
		logic q_big;
		logic split_bad;
		logic both_even;
		logic a_even;
		logic b_even;
		logic a_ne_b;
		logic seg_bad;
		logic seg_more;
		logic att_last;
	} flags_t;

	typedef logic [3:0] upc_t;

	typedef struct packed {
		op_t   op;
		cond_t cond;
		upc_t  target;
	} uword_t;

	// Program addresses
	localparam upc_t S_CHECK_RATE = 4'd0;
	localparam upc_t S_DIVIDE     = 4'd1;
	localparam upc_t S_CHECK_Q    = 4'd2;
	localparam upc_t S_BASE       = 4'd3;
	localparam upc_t S_SPLIT      = 4'd4;
	localparam upc_t S_GCD_PAIR   = 4'd5;
	localparam upc_t S_A_HALVE    = 4'd6;
	localparam upc_t S_B_HALVE    = 4'd7;
	localparam upc_t S_GCD_SUB    = 4'd8;
	localparam upc_t S_SET_P      = 4'd9;
	localparam upc_t S_SEG_INIT   = 4'd10;
	localparam upc_t S_SEG_STEP   = 4'd11;
	localparam upc_t S_EMIT_OK    = 4'd12;
	localparam upc_t S_NEXT_ATT   = 4'd13;
	localparam upc_t S_RETRY      = 4'd14;
	localparam upc_t S_EMIT_FAIL  = 4'd15;

	// Control store: the op runs every step, the jump is taken when cond holds
	function automatic uword_t ucode_word(input upc_t pc);
		uword_t w;
		unique case (pc)
			S_CHECK_RATE: w = '{OP_NOP,       C_RATE_ZERO, S_EMIT_FAIL};
			S_DIVIDE:     w = '{OP_DIV_STEP,  C_DIV_MORE,  S_DIVIDE};
			S_CHECK_Q:    w = '{OP_NOP,       C_Q_BIG,     S_EMIT_FAIL};
			S_BASE:       w = '{OP_BASE,      C_NEVER,     S_CHECK_RATE};
			S_SPLIT:      w = '{OP_SPLIT,     C_SPLIT_BAD, S_NEXT_ATT};
			S_GCD_PAIR:   w = '{OP_GCD_PAIR,  C_BOTH_EVEN, S_GCD_PAIR};
			S_A_HALVE:    w = '{OP_A_HALVE,   C_A_EVEN,    S_A_HALVE};
			S_B_HALVE:    w = '{OP_B_HALVE,   C_B_EVEN,    S_B_HALVE};
			S_GCD_SUB:    w = '{OP_GCD_SUB,   C_A_NE_B,    S_B_HALVE};
			S_SET_P:      w = '{OP_SET_P,     C_NEVER,     S_CHECK_RATE};
			S_SEG_INIT:   w = '{OP_SEG_INIT,  C_SEG_BAD,   S_NEXT_ATT};
			S_SEG_STEP:   w = '{OP_SEG_STEP,  C_SEG_MORE,  S_SEG_STEP};
			S_EMIT_OK:    w = '{OP_EMIT_OK,   C_NEVER,     S_CHECK_RATE};
			S_NEXT_ATT:   w = '{OP_ATT_INC,   C_ATT_LAST,  S_EMIT_FAIL};
			S_RETRY:      w = '{OP_NOP,       C_ALWAYS,    S_SPLIT};
			S_EMIT_FAIL:  w = '{OP_EMIT_FAIL, C_NEVER,     S_CHECK_RATE};
			default:      w = '{OP_EMIT_FAIL, C_NEVER,     S_CHECK_RATE};
		endcase
		return w;
	endfunction

endpackage

### src/cbts_sequencer.sv
// Microcode sequencer: step counter, control store lookup and jump logic.
// Depends on cbts_pkg for the control word, op and condition types.
module cbts_sequencer (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  cbts_pkg::flags_t flags,
	output cbts_pkg::op_t   op,
	output logic            busy
);
	import cbts_pkg::*;

	upc_t   pc_q;
	logic   busy_q;
	uword_t word;
	logic   jump;

	assign word = ucode_word(pc_q);
	assign busy = busy_q;

	// Condition select
	always_comb begin
		unique case (word.cond)
			C_NEVER:     jump = 1'b0;
			C_ALWAYS:    jump = 1'b1;
			C_RATE_ZERO: jump = flags.rate_zero;
			C_DIV_MORE:  jump = flags.div_more;
			C_Q_BIG:     jump = flags.q_big;
			C_SPLIT_BAD: jump = flags.split_bad;
			C_BOTH_EVEN: jump = flags.both_even;
			C_A_EVEN:    jump = flags.a_even;
			C_B_EVEN:    jump = flags.b_even;
			C_A_NE_B:    jump = flags.a_ne_b;
			C_SEG_BAD:   jump = flags.seg_bad;
			C_SEG_MORE:  jump = flags.seg_more;
			C_ATT_LAST:  jump = flags.att_last;
			default:     jump = 1'b0;
		endcase
	end

	// Op to the datapath: load on accept, program op while running
	always_comb begin
		if (busy_q) begin
			op = word.op;
		end else if (start) begin
			op = OP_LOAD;
		end else begin
			op = OP_NOP;
		end
	end

	// Step counter and run flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q   <= S_CHECK_RATE;
			busy_q <= 1'b0;
		end else if (!busy_q) begin
			if (start) begin
				pc_q   <= S_CHECK_RATE;
				busy_q <= 1'b1;
			end
		end else begin
			pc_q <= jump ? word.target : pc_q + upc_t'(1);
			if (word.op == OP_EMIT_OK || word.op == OP_EMIT_FAIL) begin
				busy_q <= 1'b0;
			end
		end
	end

endmodule

### src/cbts_datapath.sv
// Datapath of the solver: divider, split, binary gcd and segment counters.
// Depends on cbts_pkg; driven one op per cycle by cbts_sequencer.
module cbts_datapath #(
	parameter int MAX_PRESCALER = cbts_pkg::DEF_MAX_PRESCALER,
	parameter int MAX_SEG1      = cbts_pkg::DEF_MAX_SEG1,
	parameter int MAX_SEG2      = cbts_pkg::DEF_MAX_SEG2
) (
	input  logic              clk,
	input  logic              arst_n,
	input  cbts_pkg::op_t     op,
	input  cbts_pkg::request_t request,
	output cbts_pkg::flags_t  flags,
	output cbts_pkg::result_t result,
	output logic              done
);
	import cbts_pkg::*;

	// Largest bit length that can still give a valid split
	localparam int QMAX = MAX_PRESCALER * (MAX_SEG1 + 1 + MAX_SEG2);
	localparam int QW   = $clog2(QMAX + 1);
	localparam int KW   = $clog2(QW);
	localparam int S1W  = $clog2(MAX_SEG1 + 2);
	localparam int S2W  = $clog2(MAX_SEG2 + 1);
	localparam int MW   = QW + S1W + S2W;

	// Divider: dividend shifts through q_q, remainder in r_q
	logic [CLOCK_W-1:0] q_q;
	logic [RATE_W-1:0]  r_q;
	logic [RATE_W-1:0]  rate_q;
	logic [SP_W-1:0]    sp_q;
	logic [CNT_W-1:0]   cnt_q;
	// Split and gcd
	logic [QW-1:0]      base_q;
	logic [ATT_W-1:0]   att_q;
	logic [QW-1:0]      t1_q, t2_q, a_q, b_q, p_q;
	logic [KW-1:0]      k_q;
	logic [S1W-1:0]     n1_q;
	logic [S2W-1:0]     n2_q;
	result_t            result_q;
	logic               done_q;

	logic [RATE_W:0]    rs;
	logic               rs_ge;
	logic [QW-1:0]      q_n;
	logic [QW+SP_W-1:0] prod;
	logic [QW:0]        off, t1_ext;
	logic [QW-1:0]      t1, t2;
	logic [MW-1:0]      p_w, t1_w, t2_w;
	logic               t1_ge_p, t2_ge_p;

	// Restoring divide step
	assign rs    = {r_q, q_q[CLOCK_W-1]};
	assign rs_ge = rs >= {1'b0, rate_q};

	// Base split point
	assign q_n  = q_q[QW-1:0];
	assign prod = {{SP_W{1'b0}}, q_n} * {{QW{1'b0}}, sp_q};

	// Split with attempt offset
	always_comb begin
		unique case (att_q)
			ATT_PLUS:  off = (QW+1)'(1);
			ATT_MINUS: off = '1;
			default:   off = '0;
		endcase
	end
	assign t1_ext = {1'b0, base_q} + off;
	assign t1     = t1_ext[QW-1:0];
	assign t2     = q_n - t1;

	// Range checks on the gcd
	assign p_w     = MW'(p_q);
	assign t1_w    = MW'(t1_q);
	assign t2_w    = MW'(t2_q);
	assign t1_ge_p = t1_q >= p_q;
	assign t2_ge_p = t2_q >= p_q;

	always_comb begin
		flags.rate_zero = rate_q == '0;
		flags.div_more  = cnt_q != CNT_W'(CLOCK_W - 1);
		flags.q_big     = q_q > CLOCK_W'(QMAX);
		flags.split_bad = t1_ext[QW] || (t1 == '0) || (t1 >= q_n);
		flags.both_even = !a_q[0] && !b_q[0];
		flags.a_even    = !a_q[0];
		flags.b_even    = !b_q[0];
		flags.a_ne_b    = a_q != b_q;
		flags.seg_bad   = (p_q < QW'(2)) || (p_q > QW'(MAX_PRESCALER))
			|| (t1_w < (p_w << 1))
			|| (t1_w > p_w * MW'(MAX_SEG1 + 1))
			|| (t2_w > p_w * MW'(MAX_SEG2));
		flags.seg_more  = t1_ge_p || t2_ge_p;
		flags.att_last  = att_q == ATT_MINUS;
	end

	// Working registers
	always_ff @(posedge clk) begin
		unique case (op)
			OP_LOAD: begin
				q_q    <= request.clock_hz;
				rate_q <= request.bit_rate;
				sp_q   <= request.sample_point;
				r_q    <= '0;
				cnt_q  <= '0;
			end
			OP_DIV_STEP: begin
				r_q   <= rs_ge ? RATE_W'(rs - {1'b0, rate_q}) : rs[RATE_W-1:0];
				q_q   <= {q_q[CLOCK_W-2:0], rs_ge};
				cnt_q <= cnt_q + CNT_W'(1);
			end
			OP_BASE: begin
				base_q <= prod[QW+SP_W-1:SP_W];
				att_q  <= ATT_NONE;
			end
			OP_SPLIT: begin
				t1_q <= t1;
				t2_q <= t2;
				a_q  <= t1;
				b_q  <= t2;
				k_q  <= '0;
			end
			OP_GCD_PAIR: begin
				if (!a_q[0] && !b_q[0]) begin
					a_q <= a_q >> 1;
					b_q <= b_q >> 1;
					k_q <= k_q + KW'(1);
				end
			end
			OP_A_HALVE: begin
				if (!a_q[0]) begin
					a_q <= a_q >> 1;
				end
			end
			OP_B_HALVE: begin
				if (!b_q[0]) begin
					b_q <= b_q >> 1;
				end
			end
			OP_GCD_SUB: begin
				if (a_q > b_q) begin
					a_q <= b_q;
					b_q <= a_q - b_q;
				end else begin
					b_q <= b_q - a_q;
				end
			end
			OP_SET_P: begin
				p_q <= a_q << k_q;
			end
			OP_SEG_INIT: begin
				n1_q <= '0;
				n2_q <= '0;
			end
			OP_SEG_STEP: begin
				if (t1_ge_p) begin
					t1_q <= t1_q - p_q;
					n1_q <= n1_q + S1W'(1);
				end
				if (t2_ge_p) begin
					t2_q <= t2_q - p_q;
					n2_q <= n2_q + S2W'(1);
				end
			end
			OP_ATT_INC: begin
				att_q <= att_q + ATT_W'(1);
			end
			default: begin
			end
		endcase
	end

	// Result word
	always_ff @(posedge clk) begin
		if (op == OP_EMIT_OK) begin
			result_q.ok              <= 1'b1;
			result_q.prescaler_field <= PRESC_W'(p_q - QW'(1));
			result_q.seg1_field      <= SEG1_W'(n1_q - S1W'(2));
			result_q.seg2_field      <= SEG2_W'(n2_q - S2W'(1));
			result_q.attempt_used    <= att_q;
		end else if (op == OP_EMIT_FAIL) begin
			result_q <= '0;
		end
	end

	// Result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= (op == OP_EMIT_OK) || (op == OP_EMIT_FAIL);
		end
	end

	assign result = result_q;
	assign done   = done_q;

endmodule

### src/can_bit_timing_solver.sv
// Top level of the CAN bit-timing solver: sequencer plus datapath.
// Depends on cbts_pkg, cbts_sequencer and cbts_datapath.
//
// A word is taken when start is high and busy is low; busy then stays high
// until the result word is shown. The result is on result for exactly one
// cycle with done high and cannot be held off, so the receiver must take it
// then. One word is solved at a time. All work runs on one shared datapath
// under a 16-step microprogram: a restoring divide for clock/rate, then up
// to three split attempts, each a binary gcd (one halving or subtraction
// per cycle) and a segment count. A zero bit rate ends the run before the
// divide and an over-long bit ends it right after the divide.
module can_bit_timing_solver #(
	parameter int MAX_PRESCALER = cbts_pkg::DEF_MAX_PRESCALER,
	parameter int MAX_SEG1      = cbts_pkg::DEF_MAX_SEG1,
	parameter int MAX_SEG2      = cbts_pkg::DEF_MAX_SEG2
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  cbts_pkg::request_t request,
	output logic               done,
	output cbts_pkg::result_t  result
);
	import cbts_pkg::*;

	op_t    op;
	flags_t flags;

	// Control
	cbts_sequencer u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.flags  (flags),
		.op     (op),
		.busy   (busy)
	);

	// Arithmetic
	cbts_datapath #(
		.MAX_PRESCALER (MAX_PRESCALER),
		.MAX_SEG1      (MAX_SEG1),
		.MAX_SEG2      (MAX_SEG2)
	) u_dp (
		.clk     (clk),
		.arst_n  (arst_n),
		.op      (op),
		.request (request),
		.flags   (flags),
		.result  (result),
		.done    (done)
	);

endmodule

### src/cbts_checker.sv
// Port-level checks for can_bit_timing_solver, bound to the top level.
// Depends on cbts_pkg for the word types.
module cbts_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               start,
	input logic               busy,
	input logic               done,
	input cbts_pkg::result_t  result
);
	import cbts_pkg::*;

	// An accepted word makes the block busy
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("busy not raised after accept");

	// Busy ends exactly when the result word appears
	a_busy_ends_done: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> done)
		else $error("busy fell without a result");

	// No result while a word is still being solved
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result shown while busy");

	// A failed result carries zero fields
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && !result.ok |-> result.prescaler_field == '0
			&& result.seg1_field == '0 && result.seg2_field == '0
			&& result.attempt_used == '0)
		else $error("failure result with non-zero fields");

	// One strobe per word
	a_single_strobe: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe longer than one cycle");

endmodule

bind can_bit_timing_solver cbts_checker u_cbts_checker (
	.clk     (clk),
	.arst_n  (arst_n),
	.start   (start),
	.busy    (busy),
	.done    (done),
	.result  (result)
);
